// ===== hw/rtl/cplw_pkg.sv =====
// ----------------------------------------------------------------------------
// cplw_pkg
// Types, codes and sizing constants of the cyclic piecewise-linear warp.
// ----------------------------------------------------------------------------
package cplw_pkg;

    localparam int MAX_POINTS = 32;
    localparam int ANGLE_BITS = 16;
    localparam int IDX_BITS   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_BITS   = $clog2(MAX_POINTS + 1);

    // action codes
    localparam logic [2:0] ACT_CLEAR   = 3'd0;
    localparam logic [2:0] ACT_WRITE   = 3'd1;
    localparam logic [2:0] ACT_COMMIT  = 3'd2;
    localparam logic [2:0] ACT_WARP    = 3'd3;
    localparam logic [2:0] ACT_UNWARP  = 3'd4;

    localparam logic ST_OK     = 1'b0;
    localparam logic ST_REJECT = 1'b1;

    typedef struct packed {
        logic [2:0]            action;
        logic [IDX_BITS-1:0]   point_index;
        logic [ANGLE_BITS-1:0] raw_angle;
        logic [ANGLE_BITS-1:0] warped_angle;
        logic [CNT_BITS-1:0]   point_count;
        logic [ANGLE_BITS-1:0] angle_in;
    } t_in_word;

    typedef struct packed {
        logic [ANGLE_BITS-1:0] angle_out;
        logic                  status;
    } t_out_word;

endpackage

// ===== hw/rtl/cplw_ram.sv =====
// ----------------------------------------------------------------------------
// cplw_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module cplw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write one entry when enabled; read the addressed entry every cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/cyclic_piecewise_linear_warp.sv =====
// ----------------------------------------------------------------------------
// cyclic_piecewise_linear_warp
// Angle warp over a cyclic table of (raw, warped) pairs held in one RAM.
// ----------------------------------------------------------------------------
// Sequence: clear/write and identity mapping go straight to the result
// register; commit reads and checks each interval in turn (S_RD0, S_RD1,
// S_CHK); warp/unwarp examine intervals the same way and, once one matches,
// run the multiply, serial divide and output (S_MUL, S_DIV, S_OUT). One word
// at a time: the next word is taken the cycle after the result word leaves.
// Reset: identity mapping, one point in use; table contents undefined.
// ----------------------------------------------------------------------------
module cyclic_piecewise_linear_warp
    import cplw_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_word  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_word o_data
);

    localparam int AW = IDX_BITS;
    localparam int CW = CNT_BITS;
    localparam int A  = ANGLE_BITS;
    localparam int NW = A + 1;          // numerator/span width
    localparam int PW = 2 * A + 1;      // product width

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_RD0   = 8'b0000_0010,
        S_RD1   = 8'b0000_0100,
        S_CHK   = 8'b0000_1000,
        S_MUL   = 8'b0001_0000,
        S_DIV   = 8'b0010_0000,
        S_OUT   = 8'b0100_0000,
        S_FIN   = 8'b1000_0000
    } t_state;

    t_state          r_state;
    t_in_word        r_in;
    logic [CW-1:0]   r_used;
    logic            r_tvalid;
    logic [CW-1:0]   r_i;        // interval index
    logic [CW-1:0]   r_cnt;
    logic [A-1:0]    r_fr, r_fw; // first pair
    logic [A-1:0]    r_pr, r_pw; // current pair i
    logic [CW-1:0]   r_jr, r_jw; // jump counts
    logic [NW-1:0]   r_num, r_span;
    logic [A:0]      r_dd;
    logic [A-1:0]    r_base;
    logic [PW-1:0]   r_rem;
    logic [PW-1:0]   r_quo;
    logic [$clog2(PW+1)-1:0] r_step;
    logic            r_ovalid;
    t_out_word       r_out;

    logic            ram_we;
    logic [AW-1:0]   ram_addr;
    logic [2*A-1:0]  ram_rd;
    logic [A-1:0]    rd_r, rd_w;

    assign rd_r = ram_rd[2*A-1:A];
    assign rd_w = ram_rd[A-1:0];

    cplw_ram #(.WIDTH(2 * A), .DEPTH(MAX_POINTS)) u_tab (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata({i_data.raw_angle, i_data.warped_angle}),
        .o_rdata(ram_rd)
    );

    // accept a word only when idle and the output register is free
    assign o_ready = (r_state == S_IDLE) && !r_ovalid;
    logic acc;
    assign acc = i_valid && o_ready;

    assign ram_we = acc && (i_data.action == ACT_WRITE) &&
                    ({{(32-AW){1'b0}}, i_data.point_index} < MAX_POINTS);

    // next pair index j of interval i, within r_cnt
    logic [CW-1:0] nxt_i;
    assign nxt_i = (r_i + 1'b1 == r_cnt) ? '0 : r_i + 1'b1;

    always_comb begin
        if (r_state == S_IDLE) begin
            ram_addr = i_data.point_index;
        end else begin
            ram_addr = nxt_i[AW-1:0];
        end
        if (r_state == S_IDLE && !acc) begin
            ram_addr = '0;
        end
        if (acc && i_data.action != ACT_WRITE) begin
            ram_addr = '0;
        end
    end

    // interval test on pair (r_p*) and next pair (j = read data or first)
    logic          is_warp;
    logic [A-1:0]  si, sj, di, dj, ang;
    logic [NW-1:0] dj_ext, num_c, span_c;
    logic          hit;
    logic          last_i;
    assign is_warp = (r_in.action == ACT_WARP);
    assign last_i  = (r_i + 1'b1 == r_cnt);
    assign ang     = r_in.angle_in;

    always_comb begin
        logic [A-1:0] jr, jw;
        jr = last_i ? r_fr : rd_r;
        jw = last_i ? r_fw : rd_w;
        si = is_warp ? r_pr : r_pw;
        sj = is_warp ? jr : jw;
        di = is_warp ? r_pw : r_pr;
        dj = is_warp ? jw : jr;
        dj_ext = (di >= dj) ? {1'b1, dj} : {1'b0, dj};
        hit    = 1'b1;
        num_c  = '0;
        span_c = {1'b0, sj} + {1'b1, {A{1'b0}}} - {1'b0, si};
        if (si <= ang && ang <= sj && si != sj) begin
            num_c  = {1'b0, ang} - {1'b0, si};
            span_c = {1'b0, sj} - {1'b0, si};
        end else if (si >= sj && ang >= si) begin
            num_c  = {1'b0, ang} - {1'b0, si};
        end else if (si >= sj && ang <= sj) begin
            num_c  = {1'b0, ang} + {1'b1, {A{1'b0}}} - {1'b0, si};
        end else begin
            hit = 1'b0;
        end
        if (span_c == '0) begin
            hit = 1'b0;
        end
    end

    // sequence check on pair (r_p*) against next pair
    logic [A-1:0] cjr, cjw;
    assign cjr = last_i ? r_fr : rd_r;
    assign cjw = last_i ? r_fw : rd_w;

    logic [PW-1:0] sum_out;
    assign sum_out = {{(PW-A){1'b0}}, r_base} + r_quo;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_used   <= CW'(1);
            r_tvalid <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    t_out_word res;
                    res = '{angle_out: '0, status: ST_OK};
                    if (acc) begin
                        r_in <= i_data;
                        r_i  <= '0;
                        r_jr <= '0;
                        r_jw <= '0;
                        unique case (i_data.action)
                            ACT_CLEAR: begin
                                r_tvalid <= 1'b0;
                                r_used   <= CW'(1);
                                r_state  <= S_FIN;
                            end
                            ACT_WRITE: begin
                                if (ram_we) begin
                                    r_tvalid <= 1'b0;
                                    r_used   <= CW'(1);
                                end
                                r_state <= S_FIN;
                            end
                            ACT_COMMIT: begin
                                if (i_data.point_count == '0 ||
                                    {{(32-CW){1'b0}}, i_data.point_count} > MAX_POINTS) begin
                                    r_tvalid <= 1'b0;
                                    r_used   <= CW'(1);
                                    res.status = ST_REJECT;
                                    r_state <= S_FIN;
                                end else begin
                                    r_cnt   <= i_data.point_count;
                                    r_state <= S_RD0;
                                end
                            end
                            ACT_WARP, ACT_UNWARP: begin
                                if (!r_tvalid) begin
                                    res.angle_out = i_data.angle_in;
                                    r_state <= S_FIN;
                                end else begin
                                    r_cnt   <= r_used;
                                    r_state <= S_RD0;
                                end
                            end
                            default: r_state <= S_FIN;
                        endcase
                        r_out <= res;
                    end
                end
                // pair i now valid: keep as current pair, and as first at i = 0
                S_RD0: begin
                    if (r_i == '0) begin
                        r_fr <= rd_r;
                        r_fw <= rd_w;
                    end
                    r_pr <= rd_r;
                    r_pw <= rd_w;
                    r_state <= S_RD1;
                end
                // wait for pair j
                S_RD1: begin
                    r_state <= S_CHK;
                end
                // rd holds pair j (address nxt_i held since S_RD0)
                S_CHK: begin
                    if (r_in.action == ACT_COMMIT) begin
                        logic [CW-1:0] jr2, jw2;
                        jr2 = r_jr + CW'(r_pr >= cjr);
                        jw2 = r_jw + CW'(r_pw >= cjw);
                        r_jr <= jr2;
                        r_jw <= jw2;
                        if (last_i) begin
                            if (jr2 <= CW'(1) && jw2 <= CW'(1)) begin
                                r_used   <= r_cnt;
                                r_tvalid <= 1'b1;
                            end else begin
                                r_used   <= CW'(1);
                                r_tvalid <= 1'b0;
                                r_out.status <= ST_REJECT;
                            end
                            r_state <= S_FIN;
                        end else begin
                            r_i  <= nxt_i;
                            r_pr <= rd_r;
                            r_pw <= rd_w;
                            r_state <= S_RD0;
                        end
                    end else if (hit) begin
                        r_num  <= num_c;
                        r_span <= span_c;
                        r_dd   <= dj_ext - {1'b0, di};
                        r_base <= di;
                        r_state <= S_MUL;
                    end else if (last_i) begin
                        r_out.angle_out <= ang;
                        r_state <= S_FIN;
                    end else begin
                        r_i  <= nxt_i;
                        r_pr <= rd_r;
                        r_pw <= rd_w;
                        r_state <= S_RD0;
                    end
                end
                // one multiply, registered
                S_MUL: begin
                    r_rem  <= {{(PW-NW){1'b0}}, r_num} * {{(PW-NW){1'b0}}, r_dd};
                    r_quo  <= '0;
                    r_step <= '0;
                    r_state <= S_DIV;
                end
                // restoring division, one quotient bit a cycle
                S_DIV: begin
                    logic [PW-1:0] qb;
                    logic [PW-1:0] hi;
                    qb = PW'(1) << (PW - 1 - r_step);
                    hi = r_rem >> (PW - 1 - r_step);
                    if (hi >= {{(PW-NW){1'b0}}, r_span}) begin
                        r_rem <= r_rem - (PW'(r_span) << (PW - 1 - r_step));
                        r_quo <= r_quo | qb;
                    end
                    if (r_step == $bits(r_step)'(PW - 1)) begin
                        r_state <= S_OUT;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_OUT: begin
                    r_out.angle_out <= sum_out[A-1:0];
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_out;

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the cyclic piecewise-linear warp: a queue-fed driver
// and a clocked monitor compare every result word with a predicted one.
// ----------------------------------------------------------------------------
module tb_top
    import cplw_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPTS     = 32;
    localparam int WDOG_MAX = 20000;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_word  in_word = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_word out_word;

    cyclic_piecewise_linear_warp u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (in_valid),
        .o_ready (in_ready),
        .i_data  (in_word),
        .o_valid (out_valid),
        .i_ready (out_ready),
        .o_data  (out_word)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // predictor state
    logic [15:0] raw_tab [NPTS];
    logic [15:0] wrp_tab [NPTS];
    bit          written [NPTS];
    int          n_used = 1;
    bit          tab_ok = 1'b0;

    t_in_word    pending_words[$];
    t_out_word   expected_words[$];
    int          errors = 0;
    int          n_sent = 0;
    int          n_checked = 0;
    int          n_rejects = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_off = 0;
    int          quiet = 0;

    // append one word to the stimulus queue
    task automatic q_put(t_in_word w);
        pending_words.insert(pending_words.size(), w);
    endtask

    function automatic bit seq_good(ref logic [15:0] t [NPTS], input int n);
        int jumps;
        jumps = 0;
        for (int i = 0; i < n; i++) begin
            if (t[i] >= t[(i + 1 == n) ? 0 : i + 1]) jumps++;
        end
        return jumps <= 1;
    endfunction

    // true when every slot below cnt holds data
    function automatic bit covered(int cnt);
        for (int i = 0; i < cnt; i++) begin
            if (!written[i]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [15:0] map_angle(bit fwd, logic [15:0] a);
        logic [16:0] si, sj, di, dj, num, span;
        logic [33:0] prod;
        int j;
        if (!tab_ok) return a;
        for (int i = 0; i < n_used; i++) begin
            j  = (i + 1 == n_used) ? 0 : i + 1;
            si = fwd ? raw_tab[i] : wrp_tab[i];
            sj = fwd ? raw_tab[j] : wrp_tab[j];
            di = fwd ? wrp_tab[i] : raw_tab[i];
            dj = fwd ? wrp_tab[j] : raw_tab[j];
            if (di >= dj) dj += 17'h10000;
            if (si <= a && a <= sj && si != sj) begin
                num = a - si; span = sj - si;
            end else if (si >= sj && a >= si) begin
                num = a - si; span = sj + 17'h10000 - si;
            end else if (si >= sj && a <= sj) begin
                num = a + 17'h10000 - si; span = sj + 17'h10000 - si;
            end else begin
                continue;
            end
            if (span == 0) continue;
            prod = num * (dj - di);
            return 16'(di + prod / span);
        end
        return a;
    endfunction

    // compute the result word for one accepted input word and advance state
    function automatic t_out_word predict_warp(t_in_word w);
        t_out_word r;
        r = '0;
        case (w.action)
            ACT_CLEAR: begin
                tab_ok = 1'b0; n_used = 1;
            end
            ACT_WRITE: begin
                raw_tab[w.point_index] = w.raw_angle;
                wrp_tab[w.point_index] = w.warped_angle;
                tab_ok = 1'b0; n_used = 1;
            end
            ACT_COMMIT: begin
                if (w.point_count >= 1 && w.point_count <= NPTS &&
                    seq_good(raw_tab, w.point_count) &&
                    seq_good(wrp_tab, w.point_count)) begin
                    n_used = w.point_count; tab_ok = 1'b1;
                end else begin
                    tab_ok = 1'b0; n_used = 1; r.status = ST_REJECT;
                end
            end
            ACT_WARP:   r.angle_out = map_angle(1'b1, w.angle_in);
            ACT_UNWARP: r.angle_out = map_angle(1'b0, w.angle_in);
            default: ;
        endcase
        return r;
    endfunction

    // driver: hold the word until accepted, then advance
    always @(posedge clk) begin
        if (in_valid && in_ready) begin
            expected_words.insert(expected_words.size(), predict_warp(in_word));
            n_sent++;
        end
        if (!in_valid || in_ready) begin
            if (rst_n && pending_words.size() > 0 &&
                $urandom_range(99) >= send_idle_pct) begin
                in_word  <= pending_words.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
                in_word  <= $bits(t_in_word)'({$urandom, $urandom});
            end
        end
    end

    // monitor: check each result word against the oldest expectation
    always @(posedge clk) begin
        t_out_word exp_w;
        if (out_valid && out_ready) begin
            if (expected_words.size() == 0) begin
                $error("result word with nothing expected: %h", out_word);
                errors++;
            end else begin
                exp_w = expected_words.pop_front();
                n_checked++;
                if (out_word.status) n_rejects++;
                if (out_word.angle_out !== exp_w.angle_out) begin
                    $error("angle_out expected %0d actual %0d",
                           exp_w.angle_out, out_word.angle_out);
                    errors++;
                end
                if (out_word.status !== exp_w.status) begin
                    $error("status expected %0d actual %0d",
                           exp_w.status, out_word.status);
                    errors++;
                end
            end
        end
        if (hold_off > 0) begin
            hold_off--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog: count cycles with no handshake on either side
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= WDOG_MAX) begin
            $display("watchdog expired after %0d quiet cycles", quiet);
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic t_in_word mk(logic [2:0] act);
        t_in_word w;
        w = $bits(t_in_word)'({$urandom, $urandom});
        w.action = act;
        return w;
    endfunction

    // queue a write, tracking which slots hold data
    task automatic q_write(int idx, logic [15:0] r, logic [15:0] wv);
        t_in_word w;
        w = mk(ACT_WRITE);
        w.point_index = IDX_BITS'(idx); w.raw_angle = r; w.warped_angle = wv;
        written[idx] = 1'b1;
        q_put(w);
    endtask

    task automatic q_commit(int cnt);
        t_in_word w;
        w = mk(ACT_COMMIT);
        w.point_count = CNT_BITS'(cnt);
        q_put(w);
    endtask

    task automatic q_map(int nmaps);
        for (int k = 0; k < nmaps; k++) begin
            q_put(mk($urandom_range(1) ? ACT_WARP : ACT_UNWARP));
        end
    endtask

    // write a cyclic table of n points, rotated and offset; well-formed unless bad and n > 2
    task automatic q_table(int n, bit bad);
        logic [15:0] rv [NPTS];
        logic [15:0] wv [NPTS];
        int rot;
        logic [15:0] ro, wo;
        rot = $urandom_range(n - 1);
        ro = 16'($urandom); wo = 16'($urandom);
        for (int i = 0; i < n; i++) begin
            rv[i] = ro + 16'((i * 65536) / n) + 16'($urandom_range(65536 / n / 2));
            wv[i] = wo + 16'((i * 65536) / n) + 16'($urandom_range(65536 / n / 2));
        end
        if (bad && n > 2) begin
            rv[n / 2] = rv[0];
        end
        for (int i = 0; i < n; i++) begin
            q_write((i + rot) % n, rv[i], wv[i]);
        end
    endtask

    // wait until every expected word has come back
    task automatic drain;
        wait (pending_words.size() == 0 && !in_valid);
        while (expected_words.size() > 0) @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    initial begin
        t_in_word w;
        int n;
        int cnt;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: identity, extremes, every action, bad counts
        w = mk(ACT_WARP);   w.angle_in = 16'h0000; q_put(w);
        w = mk(ACT_UNWARP); w.angle_in = 16'hFFFF; q_put(w);
        for (logic [2:0] c = 5; c != 0; c++) q_put(mk(c));
        q_write(0, 16'h0000, 16'hFFFF);
        q_write(31, 16'hFFFF, 16'h0000);
        q_commit(0);
        q_commit(33);
        q_commit(63);
        q_commit(1);
        q_map(3);
        q_write(1, 16'h8000, 16'h4000);
        q_commit(2);
        w = mk(ACT_WARP); w.angle_in = 16'h8000; q_put(w);
        w = mk(ACT_WARP); w.angle_in = 16'hFFFF; q_put(w);
        w = mk(ACT_UNWARP); w.angle_in = 16'h0000; q_put(w);
        q_put(mk(ACT_CLEAR));
        q_map(2);
        drain();

        // random: tables of mostly small sizes, commits, maps; three idle phases
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 36 : (ph == 1) ? 81 : 0;
            recv_idle_pct = (ph == 0) ? 81 : (ph == 1) ? 36 : 0;
            if (ph == 2) hold_off = 400;
            while (n_sent + pending_words.size() < 110 + ph * 335) begin
                n = ($urandom_range(9) == 0) ? NPTS : $urandom_range(1, 8);
                q_table(n, $urandom_range(5) == 0);
                cnt = ($urandom_range(9) == 0) ? $urandom_range(63) : n;
                if (cnt >= 1 && cnt <= NPTS && !covered(cnt)) cnt = n;
                q_commit(cnt);
                if ($urandom_range(9) == 0) q_put(mk(ACT_CLEAR));
                if ($urandom_range(9) == 0) begin
                    w = mk(3'($urandom_range(5, 7)));
                    q_put(w);
                end
                q_map($urandom_range(4, 14));
            end
            drain();
        end

        $display("checked %0d result words from %0d input words, %0d rejected commits",
                 n_checked, n_sent, n_rejects);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // commits only ever cover slots written since reset
    initial begin
        for (int i = 0; i < NPTS; i++) written[i] = 1'b0;
    end
endmodule

// ===== filelist.f =====
hw/rtl/cplw_pkg.sv
hw/rtl/cplw_ram.sv
hw/rtl/cyclic_piecewise_linear_warp.sv
dv/tb_top.sv
